// ===== src/hcm_pkg.sv =====
// Shared types and constants for the homography coordinate map.
// Used by every module in src; depends on nothing.
`default_nettype none
package hcm_pkg;

    localparam int COORD_W         = 32;
    localparam int CFG_W           = 64;
    localparam int CFG_ADDR_W      = 3;
    localparam int QUOT_W          = 32;
    localparam int MAG_W           = 64;
    localparam int SUM_W           = 66;
    localparam int COORD_FRAC_DEF  = 16;
    localparam int COEF_FRAC_DEF   = 24;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1_A   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW1_B   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW2     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW3     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW3_C   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SHIFT    = 3'd5;

    // Matrix coefficients as seen by the datapath.
    typedef struct packed {
        logic signed [COORD_W-1:0] r11, r12, r13;
        logic signed [COORD_W-1:0] r21, r22, r23;
        logic signed [COORD_W-1:0] r31, r32, r33;
        logic signed [COORD_W-1:0] shift_x, shift_y;
    } coef_t;

    // One item travelling down the divider chain.
    typedef struct packed {
        logic [MAG_W-1:0]  den;
        logic [MAG_W-1:0]  rem_x;
        logic [MAG_W-1:0]  rem_y;
        logic [QUOT_W-1:0] low_x;
        logic [QUOT_W-1:0] low_y;
        logic [QUOT_W-1:0] quot_x;
        logic [QUOT_W-1:0] quot_y;
        logic              neg_x;
        logic              neg_y;
        logic              over_x;
        logic              over_y;
        logic              view;
        logic              last;
    } div_item_t;

endpackage
`default_nettype wire

// ===== src/hcm_front.sv =====
// Front pipeline: shift with saturation, products, sums, magnitudes and
// the overflow check that seeds the divider chain. Depends on hcm_pkg.
`default_nettype none
module hcm_front #(
    parameter int COORD_FRAC_BITS = hcm_pkg::COORD_FRAC_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire hcm_pkg::coef_t                     coef,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [hcm_pkg::COORD_W-1:0] x_in,
    input  wire logic signed [hcm_pkg::COORD_W-1:0] y_in,
    input  wire logic                               last_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output hcm_pkg::div_item_t                      out_data
);

    localparam int HI_SHIFT = hcm_pkg::QUOT_W - COORD_FRAC_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic signed [hcm_pkg::COORD_W-1:0] xs_reg, ys_reg, xs_next, ys_next;
    logic                               last1_reg, last2_reg, last3_reg, last4_reg;
    logic signed [63:0] p11_reg, p12_reg, p21_reg, p22_reg, p31_reg, p32_reg;
    logic signed [hcm_pkg::SUM_W-1:0] sd_reg, sx_reg, sy_reg;
    logic signed [hcm_pkg::SUM_W-1:0] c13, c23, c33;
    logic [hcm_pkg::MAG_W-1:0] dmag_reg, xmag_reg, ymag_reg;
    logic [hcm_pkg::MAG_W-1:0] dmag_next, xmag_next, ymag_next;
    logic xneg_reg, yneg_reg, view_reg, view_next;
    logic [hcm_pkg::SUM_W-1:0] dneg_val, xneg_val, yneg_val;
    logic [hcm_pkg::MAG_W-1:0] hi_x, hi_y;
    hcm_pkg::div_item_t item_reg, item_next;
    logic [hcm_pkg::COORD_W:0] sum_x, sum_y;

    // Each stage moves when it is empty or the next one moves.
    assign rdy5      = !v5_reg || out_ready;
    assign rdy4      = !v4_reg || rdy5;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign out_valid = v5_reg;
    assign out_data  = item_reg;

    // Shift and saturate to the coordinate range.
    always_comb
    begin
        sum_x = {x_in[hcm_pkg::COORD_W-1], x_in}
              + {coef.shift_x[hcm_pkg::COORD_W-1], coef.shift_x};
        sum_y = {y_in[hcm_pkg::COORD_W-1], y_in}
              + {coef.shift_y[hcm_pkg::COORD_W-1], coef.shift_y};
        xs_next = sum_x[hcm_pkg::COORD_W-1:0];
        ys_next = sum_y[hcm_pkg::COORD_W-1:0];
        if (sum_x[hcm_pkg::COORD_W] != sum_x[hcm_pkg::COORD_W-1])
        begin
            xs_next = sum_x[hcm_pkg::COORD_W] ? {1'b1, {(hcm_pkg::COORD_W-1){1'b0}}}
                                              : {1'b0, {(hcm_pkg::COORD_W-1){1'b1}}};
        end
        if (sum_y[hcm_pkg::COORD_W] != sum_y[hcm_pkg::COORD_W-1])
        begin
            ys_next = sum_y[hcm_pkg::COORD_W] ? {1'b1, {(hcm_pkg::COORD_W-1){1'b0}}}
                                              : {1'b0, {(hcm_pkg::COORD_W-1){1'b1}}};
        end
    end

    // Constant terms lined up with the products.
    assign c13 = hcm_pkg::SUM_W'(coef.r13) <<< COORD_FRAC_BITS;
    assign c23 = hcm_pkg::SUM_W'(coef.r23) <<< COORD_FRAC_BITS;
    assign c33 = hcm_pkg::SUM_W'(coef.r33) <<< COORD_FRAC_BITS;

    // Sign and magnitude of the three sums.
    always_comb
    begin
        dneg_val  = -sd_reg;
        xneg_val  = -sx_reg;
        yneg_val  = -sy_reg;
        dmag_next = sd_reg[hcm_pkg::SUM_W-1] ? dneg_val[hcm_pkg::MAG_W-1:0]
                                             : sd_reg[hcm_pkg::MAG_W-1:0];
        xmag_next = sx_reg[hcm_pkg::SUM_W-1] ? xneg_val[hcm_pkg::MAG_W-1:0]
                                             : sx_reg[hcm_pkg::MAG_W-1:0];
        ymag_next = sy_reg[hcm_pkg::SUM_W-1] ? yneg_val[hcm_pkg::MAG_W-1:0]
                                             : sy_reg[hcm_pkg::MAG_W-1:0];
        view_next = !sd_reg[hcm_pkg::SUM_W-1] && (sd_reg != '0);
    end

    // Seed the divider: high part becomes the remainder, the rest is fed in.
    always_comb
    begin
        hi_x = xmag_reg >> HI_SHIFT;
        hi_y = ymag_reg >> HI_SHIFT;
        item_next.den    = dmag_reg;
        item_next.rem_x  = hi_x;
        item_next.rem_y  = hi_y;
        item_next.low_x  = hcm_pkg::QUOT_W'(xmag_reg << COORD_FRAC_BITS);
        item_next.low_y  = hcm_pkg::QUOT_W'(ymag_reg << COORD_FRAC_BITS);
        item_next.quot_x = '0;
        item_next.quot_y = '0;
        item_next.neg_x  = xneg_reg;
        item_next.neg_y  = yneg_reg;
        item_next.over_x = hi_x >= dmag_reg;
        item_next.over_y = hi_y >= dmag_reg;
        item_next.view   = view_reg;
        item_next.last   = last4_reg;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            xs_reg    <= xs_next;
            ys_reg    <= ys_next;
            last1_reg <= last_in;
        end
        if (rdy2)
        begin
            p11_reg   <= coef.r11 * xs_reg;
            p12_reg   <= coef.r12 * ys_reg;
            p21_reg   <= coef.r21 * xs_reg;
            p22_reg   <= coef.r22 * ys_reg;
            p31_reg   <= coef.r31 * xs_reg;
            p32_reg   <= coef.r32 * ys_reg;
            last2_reg <= last1_reg;
        end
        if (rdy3)
        begin
            sd_reg    <= hcm_pkg::SUM_W'(p31_reg) + hcm_pkg::SUM_W'(p32_reg) + c33;
            sx_reg    <= hcm_pkg::SUM_W'(p11_reg) + hcm_pkg::SUM_W'(p12_reg) + c13;
            sy_reg    <= hcm_pkg::SUM_W'(p21_reg) + hcm_pkg::SUM_W'(p22_reg) + c23;
            last3_reg <= last2_reg;
        end
        if (rdy4)
        begin
            dmag_reg  <= dmag_next;
            xmag_reg  <= xmag_next;
            ymag_reg  <= ymag_next;
            xneg_reg  <= sx_reg[hcm_pkg::SUM_W-1];
            yneg_reg  <= sy_reg[hcm_pkg::SUM_W-1];
            view_reg  <= view_next;
            last4_reg <= last3_reg;
        end
        if (rdy5)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/hcm_div_cell.sv =====
// One cell of the divider chain: one quotient bit for both coordinates.
// Depends on hcm_pkg.
`default_nettype none
module hcm_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hcm_pkg::div_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hcm_pkg::div_item_t      out_data
);

    logic               valid_reg;
    hcm_pkg::div_item_t data_reg, data_next;
    logic [hcm_pkg::MAG_W:0] trial_x, trial_y;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Shift in the next numerator bit and subtract the divisor when it fits.
    always_comb
    begin
        data_next = in_data;
        trial_x   = {in_data.rem_x, in_data.low_x[hcm_pkg::QUOT_W-1]};
        trial_y   = {in_data.rem_y, in_data.low_y[hcm_pkg::QUOT_W-1]};
        data_next.low_x = in_data.low_x << 1;
        data_next.low_y = in_data.low_y << 1;
        if (trial_x >= {1'b0, in_data.den})
        begin
            data_next.rem_x  = hcm_pkg::MAG_W'(trial_x - {1'b0, in_data.den});
            data_next.quot_x = {in_data.quot_x[hcm_pkg::QUOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem_x  = hcm_pkg::MAG_W'(trial_x);
            data_next.quot_x = {in_data.quot_x[hcm_pkg::QUOT_W-2:0], 1'b0};
        end
        if (trial_y >= {1'b0, in_data.den})
        begin
            data_next.rem_y  = hcm_pkg::MAG_W'(trial_y - {1'b0, in_data.den});
            data_next.quot_y = {in_data.quot_y[hcm_pkg::QUOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem_y  = hcm_pkg::MAG_W'(trial_y);
            data_next.quot_y = {in_data.quot_y[hcm_pkg::QUOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/homography_coordinate_map_top.sv =====
// Top level of the homography coordinate map: configuration registers,
// front pipeline, divider cell chain and output register. Depends on hcm_pkg,
// hcm_front and hcm_div_cell.
`default_nettype none
// Maps one coordinate pair per item through a 3x3 projective transform and
// accepts a new item every clock cycle when the output side keeps up. An item
// passes through five front stages (shift, products, sums, magnitudes,
// overflow check), one cell per quotient bit in a chain of 32 divider cells,
// and the output register. Every stage holds its item on a stall and empty
// stages fill up, so the input keeps taking items while results wait.
// Coefficients are Q8.24, coordinates Q16.16; write the configuration only
// while no items are in flight.
module homography_coordinate_map_top #(
    parameter int COORD_FRAC_BITS = hcm_pkg::COORD_FRAC_DEF,
    parameter int COEF_FRAC_BITS  = hcm_pkg::COEF_FRAC_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [hcm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [hcm_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [2*hcm_pkg::COORD_W-1:0]     s_tdata,  // x_in, y_in
    input  wire logic                              s_tlast,  // last_in
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [2*hcm_pkg::COORD_W-1:0]          m_tdata,  // x_out, y_out
    output logic                                   m_tuser,  // in_view
    output logic                                   m_tlast   // last_out
);

    localparam int NCELL = hcm_pkg::QUOT_W;
    localparam logic [hcm_pkg::CFG_W-1:0] ONE_COEF = hcm_pkg::CFG_W'(1) << COEF_FRAC_BITS;
    localparam logic [hcm_pkg::COORD_W-1:0] S_MAX = {1'b0, {(hcm_pkg::COORD_W-1){1'b1}}};
    localparam logic [hcm_pkg::COORD_W-1:0] S_MIN = {1'b1, {(hcm_pkg::COORD_W-1){1'b0}}};

    logic [hcm_pkg::CFG_W-1:0] row1a_reg, row1b_reg, row2_reg, row3_reg, shift_reg;
    logic [hcm_pkg::COORD_W-1:0] row3c_reg;
    hcm_pkg::coef_t coef;

    logic               chain_valid [NCELL+1];
    logic               chain_ready [NCELL+1];
    hcm_pkg::div_item_t chain_data  [NCELL+1];

    logic out_valid_reg, out_ready;
    logic [hcm_pkg::COORD_W-1:0] xo_reg, yo_reg, xo_next, yo_next;
    logic view_reg, last_reg;
    hcm_pkg::div_item_t fin;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row1a_reg <= ONE_COEF;
            row1b_reg <= '0;
            row2_reg  <= ONE_COEF;
            row3_reg  <= '0;
            row3c_reg <= ONE_COEF[hcm_pkg::COORD_W-1:0];
            shift_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                hcm_pkg::REG_ROW1_A: row1a_reg <= cfg_wdata;
                hcm_pkg::REG_ROW1_B: row1b_reg <= cfg_wdata;
                hcm_pkg::REG_ROW2:   row2_reg  <= cfg_wdata;
                hcm_pkg::REG_ROW3:   row3_reg  <= cfg_wdata;
                hcm_pkg::REG_ROW3_C: row3c_reg <= cfg_wdata[hcm_pkg::COORD_W-1:0];
                hcm_pkg::REG_SHIFT:  shift_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Unpack the coefficient halves.
    always_comb
    begin
        coef.r11     = row1a_reg[31:0];
        coef.r12     = row1a_reg[63:32];
        coef.r13     = row1b_reg[31:0];
        coef.r21     = row1b_reg[63:32];
        coef.r22     = row2_reg[31:0];
        coef.r23     = row2_reg[63:32];
        coef.r31     = row3_reg[31:0];
        coef.r32     = row3_reg[63:32];
        coef.r33     = row3c_reg;
        coef.shift_x = shift_reg[31:0];
        coef.shift_y = shift_reg[63:32];
    end

    hcm_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .x_in     (s_tdata[hcm_pkg::COORD_W-1:0]),
        .y_in     (s_tdata[2*hcm_pkg::COORD_W-1:hcm_pkg::COORD_W]),
        .last_in  (s_tlast),
        .out_valid(chain_valid[0]),
        .out_ready(chain_ready[0]),
        .out_data (chain_data[0])
    );

    // Divider chain, most significant quotient bit first.
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        hcm_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (chain_valid[i]),
            .in_ready (chain_ready[i]),
            .in_data  (chain_data[i]),
            .out_valid(chain_valid[i+1]),
            .out_ready(chain_ready[i+1]),
            .out_data (chain_data[i+1])
        );
    end

    assign fin       = chain_data[NCELL];
    assign out_ready = !out_valid_reg || m_tready;
    assign chain_ready[NCELL] = out_ready;

    // Apply signs and saturate; an item out of view gives the maximum on both axes.
    always_comb
    begin
        if (!fin.view)
        begin
            xo_next = S_MAX;
            yo_next = S_MAX;
        end
        else
        begin
            if (fin.neg_x)
                xo_next = (fin.over_x || fin.quot_x > S_MIN) ? S_MIN : -fin.quot_x;
            else
                xo_next = (fin.over_x || fin.quot_x[hcm_pkg::QUOT_W-1]) ? S_MAX : fin.quot_x;
            if (fin.neg_y)
                yo_next = (fin.over_y || fin.quot_y > S_MIN) ? S_MIN : -fin.quot_y;
            else
                yo_next = (fin.over_y || fin.quot_y[hcm_pkg::QUOT_W-1]) ? S_MAX : fin.quot_y;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= chain_valid[NCELL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            xo_reg   <= xo_next;
            yo_reg   <= yo_next;
            view_reg <= fin.view;
            last_reg <= fin.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {yo_reg, xo_reg};
    assign m_tuser  = view_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire
